### rtl/core/imrs_pkg.sv
package imrs_pkg;

  typedef enum logic [1:0] {
    ACT_TRIGGER = 2'd0,
    ACT_EVENT   = 2'd1,
    ACT_TAKE    = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_SEND    = 3'd2,
    CMD_RESTART = 3'd3,
    CMD_RECEIVE = 3'd4,
    CMD_ACK     = 3'd5,
    CMD_NACK    = 3'd6,
    CMD_RELEASE = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    PH_ADDR_WR = 3'd0,
    PH_REG     = 3'd1,
    PH_RESTART = 3'd2,
    PH_ADDR_RD = 3'd3,
    PH_RX_OPEN = 3'd4,
    PH_RX_BYTE = 3'd5,
    PH_RX_NEXT = 3'd6,
    PH_DONE    = 3'd7
  } phase_t;

  localparam logic [7:0] ADDR_WR_MASK    = 8'hFE;
  localparam logic [7:0] ADDR_RD_BIT     = 8'h01;
  localparam logic [7:0] DATA_REG        = 8'h03;
  localparam logic [2:0] BURST_LEN       = 3'd6;
  localparam logic [7:0] DEV_ADDR_RESET  = 8'd60;
  localparam logic       REG_DEV_ADDR    = 1'b0;

  typedef struct packed {
    logic [1:0] action;
    logic       bus_granted;
    logic       nack;
    logic       bus_collision;
    logic       write_collision;
    logic       read_overflow;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    cmd_t               command;
    logic [7:0]         tx_byte;
    logic               active;
    logic               sample_done;
    logic signed [15:0] last_x;
    logic signed [15:0] last_y;
    logic signed [15:0] last_z;
    logic signed [31:0] sum_x;
    logic signed [31:0] sum_y;
    logic signed [31:0] sum_z;
    logic [15:0]        sample_count;
    logic [15:0]        ready_count;
  } out_word_t;

  typedef struct packed {
    phase_t             phase;
    logic               session_on;
    logic [2:0]         byte_index;
    logic signed [15:0] last_x;
    logic signed [15:0] last_y;
    logic signed [15:0] last_z;
    logic signed [31:0] sum_x;
    logic signed [31:0] sum_y;
    logic signed [31:0] sum_z;
    logic [15:0]        total_count;
    logic [15:0]        ready_tally;
  } seq_state_t;

endpackage

### rtl/core/imrs_in_if.sv
interface imrs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       bus_granted;
  logic       nack;
  logic       bus_collision;
  logic       write_collision;
  logic       read_overflow;
  logic [7:0] rx_byte;

  modport source (
    output valid, action, bus_granted, nack, bus_collision, write_collision,
           read_overflow, rx_byte,
    input  ready
  );

  modport sink (
    input  valid, action, bus_granted, nack, bus_collision, write_collision,
           read_overflow, rx_byte,
    output ready
  );
endinterface

### rtl/core/imrs_out_if.sv
interface imrs_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [7:0]         tx_byte;
  logic               active;
  logic               sample_done;
  logic signed [15:0] last_x;
  logic signed [15:0] last_y;
  logic signed [15:0] last_z;
  logic signed [31:0] sum_x;
  logic signed [31:0] sum_y;
  logic signed [31:0] sum_z;
  logic [15:0]        sample_count;
  logic [15:0]        ready_count;

  modport source (
    output valid, command, tx_byte, active, sample_done, last_x, last_y, last_z,
           sum_x, sum_y, sum_z, sample_count, ready_count,
    input  ready
  );

  modport sink (
    input  valid, command, tx_byte, active, sample_done, last_x, last_y, last_z,
           sum_x, sum_y, sum_z, sample_count, ready_count,
    output ready
  );
endinterface

### rtl/core/imrs_step.sv
module imrs_step import imrs_pkg::*; (
  input  seq_state_t st,
  input  in_word_t   w,
  input  logic [7:0] dev_addr,
  input  logic [7:0] store [6],
  output seq_state_t st_next,
  output logic       store_we,
  output logic [2:0] store_idx,
  output out_word_t  res
);

  logic               err;
  logic [2:0]         idx_inc;
  logic signed [15:0] new_x;
  logic signed [15:0] new_y;
  logic signed [15:0] new_z;
  logic signed [31:0] ext_x;
  logic signed [31:0] ext_y;
  logic signed [31:0] ext_z;
  logic               fresh;

  assign err     = w.nack | w.bus_collision | w.write_collision | w.read_overflow;
  assign idx_inc = st.byte_index + 3'd1;

  // X and Z come off the bus negated; wrap at 16 bits
  assign new_x = 16'(16'd0 - {store[0], store[1]});
  assign new_z = 16'(16'd0 - {store[2], store[3]});
  assign new_y = {store[4], store[5]};
  assign ext_x = 32'(new_x);
  assign ext_y = 32'(new_y);
  assign ext_z = 32'(new_z);
  assign fresh = (st.ready_tally == 16'd0);

  assign store_idx = st.byte_index;

  always_comb begin
    st_next         = st;
    store_we        = 1'b0;
    res             = '0;
    res.command     = CMD_NONE;
    res.tx_byte     = 8'd0;
    res.sample_done = 1'b0;

    case (action_t'(w.action))
      ACT_TRIGGER: begin
        if (!st.session_on && w.bus_granted) begin
          st_next.session_on = 1'b1;
          st_next.phase      = PH_ADDR_WR;
          res.command        = CMD_START;
        end
      end
      ACT_EVENT: begin
        if (st.session_on) begin
          if (err) begin
            st_next.session_on = 1'b0;
            res.command        = CMD_RELEASE;
          end else begin
            case (st.phase)
              PH_ADDR_WR: begin
                res.command   = CMD_SEND;
                res.tx_byte   = dev_addr & ADDR_WR_MASK;
                st_next.phase = PH_REG;
              end
              PH_REG: begin
                res.command   = CMD_SEND;
                res.tx_byte   = DATA_REG;
                st_next.phase = PH_RESTART;
              end
              PH_RESTART: begin
                res.command   = CMD_RESTART;
                st_next.phase = PH_ADDR_RD;
              end
              PH_ADDR_RD: begin
                res.command   = CMD_SEND;
                res.tx_byte   = dev_addr | ADDR_RD_BIT;
                st_next.phase = PH_RX_OPEN;
              end
              PH_RX_OPEN: begin
                res.command        = CMD_RECEIVE;
                st_next.byte_index = 3'd0;
                st_next.phase      = PH_RX_BYTE;
              end
              PH_RX_BYTE: begin
                store_we           = (st.byte_index < BURST_LEN);
                st_next.byte_index = idx_inc;
                if (idx_inc < BURST_LEN) begin
                  res.command   = CMD_ACK;
                  st_next.phase = PH_RX_NEXT;
                end else begin
                  res.command   = CMD_NACK;
                  st_next.phase = PH_DONE;
                end
              end
              PH_RX_NEXT: begin
                res.command   = CMD_RECEIVE;
                st_next.phase = PH_RX_BYTE;
              end
              PH_DONE: begin
                st_next.session_on  = 1'b0;
                res.command         = CMD_RELEASE;
                res.sample_done     = 1'b1;
                st_next.last_x      = new_x;
                st_next.last_y      = new_y;
                st_next.last_z      = new_z;
                st_next.sum_x       = fresh ? ext_x : st.sum_x + ext_x;
                st_next.sum_y       = fresh ? ext_y : st.sum_y + ext_y;
                st_next.sum_z       = fresh ? ext_z : st.sum_z + ext_z;
                st_next.total_count = st.total_count + 16'd1;
                st_next.ready_tally = st.ready_tally + 16'd1;
              end
              default: begin
                res.command = CMD_NONE;
              end
            endcase
          end
        end
      end
      default: begin
        res.command = CMD_NONE;
      end
    endcase

    res.active       = st_next.session_on;
    res.last_x       = st_next.last_x;
    res.last_y       = st_next.last_y;
    res.last_z       = st_next.last_z;
    res.sum_x        = st_next.sum_x;
    res.sum_y        = st_next.sum_y;
    res.sum_z        = st_next.sum_z;
    res.sample_count = st_next.total_count;
    // report the tally before a take drops it
    res.ready_count  = st_next.ready_tally;
    if (action_t'(w.action) == ACT_TAKE) begin
      st_next.ready_tally = 16'd0;
    end
  end

endmodule

### rtl/core/i2c_magnetometer_read_sequencer.sv
// channel   | dir | handshake     | word
// ----------+-----+---------------+-------------------------------------------
// in_ch     | in  | valid/ready   | action, bus flags, rx_byte
// out_ch    | out | valid/ready   | command, tx_byte, status, axes, sums, counts
// apb       | in  | psel/penable  | device_address at byte 0
//
// Each word passes an input register, the combinational step logic, then the
// result register; one word per cycle sustained while out_ch.ready holds.
// Sequencer state updates as a word moves into the result register.
// A stalled result holds both registers; in_ch.ready drops only when both
// are full. Synchronous reset clears state, counters and both valid flags.
module i2c_magnetometer_read_sequencer import imrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  imrs_in_if.sink     in_ch,
  imrs_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       s1_valid;
  in_word_t   s1_word;
  logic       out_valid;
  out_word_t  out_word;
  logic       out_stall;
  logic       s1_advance;
  seq_state_t st;
  seq_state_t st_next;
  logic [7:0] store [6];
  logic       store_we;
  logic [2:0] store_idx;
  out_word_t  res;
  logic [7:0] dev_addr;
  logic       cfg_write;

  assign out_stall   = out_valid && !out_ch.ready;
  assign s1_advance  = s1_valid && !out_stall;
  assign in_ch.ready = !s1_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_word.action          <= in_ch.action;
      s1_word.bus_granted     <= in_ch.bus_granted;
      s1_word.nack            <= in_ch.nack;
      s1_word.bus_collision   <= in_ch.bus_collision;
      s1_word.write_collision <= in_ch.write_collision;
      s1_word.read_overflow   <= in_ch.read_overflow;
      s1_word.rx_byte         <= in_ch.rx_byte;
    end
  end

  imrs_step u_step (
    .st        (st),
    .w         (s1_word),
    .dev_addr  (dev_addr),
    .store     (store),
    .st_next   (st_next),
    .store_we  (store_we),
    .store_idx (store_idx),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase       <= PH_ADDR_WR;
      st.session_on  <= 1'b0;
      st.byte_index  <= 3'd0;
      st.last_x      <= '0;
      st.last_y      <= '0;
      st.last_z      <= '0;
      st.sum_x       <= '0;
      st.sum_y       <= '0;
      st.sum_z       <= '0;
      st.total_count <= 16'd0;
      st.ready_tally <= 16'd0;
    end else if (s1_advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && store_we) begin
      store[store_idx] <= s1_word.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_stall) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_word <= res;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.command      = out_word.command;
  assign out_ch.tx_byte      = out_word.tx_byte;
  assign out_ch.active       = out_word.active;
  assign out_ch.sample_done  = out_word.sample_done;
  assign out_ch.last_x       = out_word.last_x;
  assign out_ch.last_y       = out_word.last_y;
  assign out_ch.last_z       = out_word.last_z;
  assign out_ch.sum_x        = out_word.sum_x;
  assign out_ch.sum_y        = out_word.sum_y;
  assign out_ch.sum_z        = out_word.sum_z;
  assign out_ch.sample_count = out_word.sample_count;
  assign out_ch.ready_count  = out_word.ready_count;

  // register file: one word-aligned register
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_DEV_ADDR);
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_DEV_ADDR) ? {24'd0, dev_addr} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr <= DEV_ADDR_RESET;
    end else if (cfg_write) begin
      dev_addr <= pwdata[7:0];
    end
  end

  a_done_releases: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.sample_done) |-> (out_word.command == CMD_RELEASE)
      && !out_word.active)
    else $error("sample completed without bus release");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_stall) |=> s1_valid && $stable(s1_word) && $stable(st))
    else $error("input register or state moved during output stall");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && res.sample_done) |=> st.total_count == $past(st.total_count) + 16'd1)
    else $error("sample count did not advance on completed sample");

  a_tx_only_send: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.command != CMD_SEND) |-> out_word.tx_byte == 8'd0)
    else $error("tx_byte nonzero outside send");

  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && !st.session_on && res.command != CMD_START)
      |-> res.command == CMD_NONE || res.command == CMD_RELEASE)
    else $error("bus command issued outside a session");

endmodule

### tb/i2c_magnetometer_read_sequencer_test.sv
module i2c_magnetometer_read_sequencer_test;
  import imrs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 300;
  localparam int ITEMS_PER_PHASE = 275;
  localparam int SETTLE_CYCLES = 8;
  localparam int BURST_EVENTS = 17;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [2:0] DEV_ADDR_PADDR = {REG_DEV_ADDR, 2'b00};

  typedef struct {
    logic [1:0] action;
    logic       granted;
    logic [3:0] flags;
    logic [7:0] rx;
    bit         typed;
    cmd_t       cmd;
    logic [7:0] tx;
    logic       on;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  imrs_in_if  in_ch ();
  imrs_out_if out_ch ();

  i2c_magnetometer_read_sequencer i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Sequencer mirror
  logic [7:0]  dev_addr = DEV_ADDR_RESET;
  phase_t      seq_phase = PH_ADDR_WR;
  logic        session = 1'b0;
  logic [2:0]  byte_idx = 3'd0;
  logic [7:0]  burst_bytes [6] = '{default: 8'h00};
  logic [15:0] axis_x = '0;
  logic [15:0] axis_y = '0;
  logic [15:0] axis_z = '0;
  logic [31:0] total_x = '0;
  logic [31:0] total_y = '0;
  logic [31:0] total_z = '0;
  logic [15:0] sample_total = '0;
  logic [15:0] ready_tally = '0;

  out_word_t bus_results_due [$];
  int  mismatches = 0;
  int  words_sent = 0;
  bit  calm_tail = 1'b0;
  bit  long_hold_pending = 1'b0;

  dir_row_t directed_rows [27] = '{
    '{ACT_EVENT,   1'b0, 4'h0, 8'h00, 1'b1, CMD_NONE,    8'h00, 1'b0},
    '{ACT_TRIGGER, 1'b0, 4'hF, 8'hFF, 1'b1, CMD_NONE,    8'h00, 1'b0},
    '{ACT_UNUSED,  1'b1, 4'hF, 8'hFF, 1'b1, CMD_NONE,    8'h00, 1'b0},
    '{ACT_TAKE,    1'b0, 4'h0, 8'h00, 1'b1, CMD_NONE,    8'h00, 1'b0},
    '{ACT_TRIGGER, 1'b1, 4'h0, 8'h00, 1'b1, CMD_START,   8'h00, 1'b1},
    '{ACT_TRIGGER, 1'b1, 4'h0, 8'h00, 1'b1, CMD_NONE,    8'h00, 1'b1},
    '{ACT_EVENT,   1'b0, 4'h0, 8'h00, 1'b1, CMD_SEND,
      DEV_ADDR_RESET & ADDR_WR_MASK, 1'b1},
    '{ACT_EVENT,   1'b0, 4'h0, 8'h00, 1'b1, CMD_SEND,    DATA_REG, 1'b1},
    '{ACT_EVENT,   1'b0, 4'h0, 8'h00, 1'b1, CMD_RESTART, 8'h00, 1'b1},
    '{ACT_EVENT,   1'b0, 4'h0, 8'h00, 1'b1, CMD_SEND,
      DEV_ADDR_RESET | ADDR_RD_BIT, 1'b1},
    '{ACT_EVENT,   1'b0, 4'h0, 8'h00, 1'b1, CMD_RECEIVE, 8'h00, 1'b1},
    // X = -0x8000 wraps to itself, Z = -0xFFFF is +1, Y is the top positive
    '{ACT_EVENT,   1'b0, 4'h0, 8'h80, 1'b0, CMD_NONE,    8'h00, 1'b0},
    '{ACT_EVENT,   1'b1, 4'h0, 8'h00, 1'b0, CMD_NONE,    8'h00, 1'b0},
    '{ACT_EVENT,   1'b0, 4'h0, 8'h00, 1'b0, CMD_NONE,    8'h00, 1'b0},
    '{ACT_EVENT,   1'b0, 4'h0, 8'h00, 1'b0, CMD_NONE,    8'h00, 1'b0},
    '{ACT_EVENT,   1'b0, 4'h0, 8'hFF, 1'b0, CMD_NONE,    8'h00, 1'b0},
    '{ACT_EVENT,   1'b0, 4'h0, 8'h00, 1'b0, CMD_NONE,    8'h00, 1'b0},
    '{ACT_EVENT,   1'b0, 4'h0, 8'hFF, 1'b0, CMD_NONE,    8'h00, 1'b0},
    '{ACT_TAKE,    1'b1, 4'hF, 8'hAA, 1'b0, CMD_NONE,    8'h00, 1'b0},
    '{ACT_EVENT,   1'b0, 4'h0, 8'h00, 1'b0, CMD_NONE,    8'h00, 1'b0},
    '{ACT_EVENT,   1'b0, 4'h0, 8'h7F, 1'b0, CMD_NONE,    8'h00, 1'b0},
    '{ACT_EVENT,   1'b0, 4'h0, 8'h00, 1'b0, CMD_NONE,    8'h00, 1'b0},
    '{ACT_EVENT,   1'b0, 4'h0, 8'hFF, 1'b0, CMD_NONE,    8'h00, 1'b0},
    '{ACT_EVENT,   1'b0, 4'h0, 8'h00, 1'b0, CMD_NONE,    8'h00, 1'b0},
    '{ACT_TRIGGER, 1'b1, 4'h0, 8'h00, 1'b1, CMD_START,   8'h00, 1'b1},
    '{ACT_EVENT,   1'b0, 4'hF, 8'hFF, 1'b1, CMD_RELEASE, 8'h00, 1'b0},
    '{ACT_TAKE,    1'b0, 4'h0, 8'h00, 1'b0, CMD_NONE,    8'h00, 1'b0}
  };

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic out_word_t predict_bus_step(in_word_t w);
    out_word_t  r;
    logic       err;
    logic [15:0] ready_seen;
    r = '0;
    r.command = CMD_NONE;
    err = w.nack | w.bus_collision | w.write_collision | w.read_overflow;
    if (w.action == ACT_TRIGGER) begin
      if (!session && w.bus_granted) begin
        session = 1'b1;
        seq_phase = PH_ADDR_WR;
        r.command = CMD_START;
      end
    end else if (w.action == ACT_EVENT && session) begin
      if (err) begin
        session = 1'b0;
        r.command = CMD_RELEASE;
      end else begin
        case (seq_phase)
          PH_ADDR_WR: begin
            r.command = CMD_SEND;
            r.tx_byte = dev_addr & ADDR_WR_MASK;
            seq_phase = PH_REG;
          end
          PH_REG: begin
            r.command = CMD_SEND;
            r.tx_byte = DATA_REG;
            seq_phase = PH_RESTART;
          end
          PH_RESTART: begin
            r.command = CMD_RESTART;
            seq_phase = PH_ADDR_RD;
          end
          PH_ADDR_RD: begin
            r.command = CMD_SEND;
            r.tx_byte = dev_addr | ADDR_RD_BIT;
            seq_phase = PH_RX_OPEN;
          end
          PH_RX_OPEN: begin
            r.command = CMD_RECEIVE;
            byte_idx = 3'd0;
            seq_phase = PH_RX_BYTE;
          end
          PH_RX_BYTE: begin
            if (byte_idx < BURST_LEN) burst_bytes[byte_idx] = w.rx_byte;
            byte_idx = byte_idx + 3'd1;
            if (byte_idx < BURST_LEN) begin
              r.command = CMD_ACK;
              seq_phase = PH_RX_NEXT;
            end else begin
              r.command = CMD_NACK;
              seq_phase = PH_DONE;
            end
          end
          PH_RX_NEXT: begin
            r.command = CMD_RECEIVE;
            seq_phase = PH_RX_BYTE;
          end
          default: begin
            session = 1'b0;
            r.command = CMD_RELEASE;
            r.sample_done = 1'b1;
            // big-endian words; X and Z flip sign with 16-bit wrap
            axis_x = 16'd0 - {burst_bytes[0], burst_bytes[1]};
            axis_z = 16'd0 - {burst_bytes[2], burst_bytes[3]};
            axis_y = {burst_bytes[4], burst_bytes[5]};
            if (ready_tally == 16'd0) begin
              total_x = {{16{axis_x[15]}}, axis_x};
              total_y = {{16{axis_y[15]}}, axis_y};
              total_z = {{16{axis_z[15]}}, axis_z};
            end else begin
              total_x = total_x + {{16{axis_x[15]}}, axis_x};
              total_y = total_y + {{16{axis_y[15]}}, axis_y};
              total_z = total_z + {{16{axis_z[15]}}, axis_z};
            end
            sample_total = sample_total + 16'd1;
            ready_tally = ready_tally + 16'd1;
          end
        endcase
      end
    end
    ready_seen = ready_tally;
    if (w.action == ACT_TAKE) ready_tally = 16'd0;
    r.active = session;
    r.last_x = axis_x;
    r.last_y = axis_y;
    r.last_z = axis_z;
    r.sum_x = total_x;
    r.sum_y = total_y;
    r.sum_z = total_z;
    r.sample_count = sample_total;
    r.ready_count = ready_seen;
    return r;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    w = in_word_t'($urandom);
    return w;
  endfunction

  task automatic offer_word(input in_word_t w);
    if (!calm_tail && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= w.action;
    in_ch.bus_granted <= w.bus_granted;
    in_ch.nack <= w.nack;
    in_ch.bus_collision <= w.bus_collision;
    in_ch.write_collision <= w.write_collision;
    in_ch.read_overflow <= w.read_overflow;
    in_ch.rx_byte <= w.rx_byte;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    bus_results_due.push_back(predict_bus_step(w));
    words_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (bus_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dev_addr(input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= DEV_ADDR_PADDR;
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    dev_addr = value;
  endtask

  // Well-formed burst with random data; stray words and bus errors mixed in
  task automatic run_session();
    in_word_t w;
    w = random_word();
    w.action = ACT_TRIGGER;
    w.bus_granted = 1'b1;
    offer_word(w);
    for (int k = 0; k < BURST_EVENTS; k++) begin
      if ($urandom_range(0, 11) == 0) begin
        w = random_word();
        case ($urandom_range(0, 2))
          0: w.action = ACT_TAKE;
          1: w.action = ACT_TRIGGER;
          default: w.action = ACT_UNUSED;
        endcase
        offer_word(w);
      end
      w = random_word();
      w.action = ACT_EVENT;
      if ($urandom_range(0, 39) == 0) begin
        {w.nack, w.bus_collision, w.write_collision, w.read_overflow} =
          4'($urandom_range(1, 15));
        offer_word(w);
        return;
      end
      {w.nack, w.bus_collision, w.write_collision, w.read_overflow} = 4'h0;
      offer_word(w);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (bus_results_due.size() == 0) begin
        $display("%0t: unexpected result word, command %0d", $time, out_ch.command);
        mismatches++;
      end else begin
        want = bus_results_due.pop_front();
        compare_field("command", 32'(want.command), 32'(out_ch.command));
        compare_field("tx_byte", 32'(want.tx_byte), 32'(out_ch.tx_byte));
        compare_field("active", 32'(want.active), 32'(out_ch.active));
        compare_field("sample_done", 32'(want.sample_done), 32'(out_ch.sample_done));
        compare_field("last_x", 32'(want.last_x), 32'(out_ch.last_x));
        compare_field("last_y", 32'(want.last_y), 32'(out_ch.last_y));
        compare_field("last_z", 32'(want.last_z), 32'(out_ch.last_z));
        compare_field("sum_x", want.sum_x, out_ch.sum_x);
        compare_field("sum_y", want.sum_y, out_ch.sum_y);
        compare_field("sum_z", want.sum_z, out_ch.sum_z);
        compare_field("sample_count", 32'(want.sample_count), 32'(out_ch.sample_count));
        compare_field("ready_count", 32'(want.ready_count), 32'(out_ch.ready_count));
      end
    end
  end

  initial begin : result_sink
    forever begin
      if (long_hold_pending) begin
        // hold off long enough for the block to fill and stall its input
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_pending = 1'b0;
      end else if (calm_tail) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    in_word_t   w;
    logic [7:0] addr_plan [5];
    bit         sender_paused;
    sender_paused = 1'b0;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_TRIGGER;
    in_ch.bus_granted <= 1'b0;
    in_ch.nack <= 1'b0;
    in_ch.bus_collision <= 1'b0;
    in_ch.write_collision <= 1'b0;
    in_ch.read_overflow <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= DEV_ADDR_PADDR;
    pwdata <= 32'd0;
    addr_plan = '{8'h00, 8'hFF, 8'h00, 8'hFE, 8'h01};
    addr_plan[2] = 8'($urandom_range(0, 255));
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      w.action = directed_rows[i].action;
      w.bus_granted = directed_rows[i].granted;
      {w.nack, w.bus_collision, w.write_collision, w.read_overflow} =
        directed_rows[i].flags;
      w.rx_byte = directed_rows[i].rx;
      offer_word(w);
      if (directed_rows[i].typed) begin
        bus_results_due[bus_results_due.size() - 1].command = directed_rows[i].cmd;
        bus_results_due[bus_results_due.size() - 1].tx_byte = directed_rows[i].tx;
        bus_results_due[bus_results_due.size() - 1].active = directed_rows[i].on;
      end
    end
    drain_results();

    for (int ph = 0; ph < 5; ph++) begin
      write_dev_addr(addr_plan[ph]);
      if (ph == 1) long_hold_pending = 1'b1;
      if (ph == 4) calm_tail = 1'b1;
      words_sent = 0;
      while (words_sent < ITEMS_PER_PHASE) begin
        // pause the sender once until every word has come back
        if (ph == 2 && !sender_paused && words_sent >= ITEMS_PER_PHASE / 2) begin
          drain_results();
          sender_paused = 1'b1;
        end
        if ($urandom_range(0, 3) != 0) begin
          run_session();
        end else begin
          repeat ($urandom_range(1, 4)) offer_word(random_word());
        end
      end
      drain_results();
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
